// File: hdl/dode_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delete-only edit distance package
// Request and response payloads, chain link types, command codes and the
// controller state encoding shared by the cell chain and the top level.
// ---------------------------------------------------------------------------
package dode_pkg;

   localparam int CHAR_W = 8;
   localparam int DIST_W = 11;

   // Request command codes.
   localparam logic CMD_FIRST  = 1'b0;
   localparam logic CMD_SECOND = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [CHAR_W-1:0] char_value;
      logic              no_char;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } rsp_type;

   // Wavefront handed from one cell to the next.
   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] ch;
   } link_type;

   // Broadcast commands to every cell.
   typedef struct packed {
      logic load;
      logic init;
      logic clear;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_STREAM,
      ST_DRAIN
   } state_type;

endpackage

// File: hdl/delete_only_edit_distance.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delete-only edit distance
// Fewest single-character deletions that make two byte strings equal.
// ---------------------------------------------------------------------------
// The first string is loaded one request per cycle into a chain of MAX_LEN
// cells, one character per cell. Second-string requests are also taken one
// per cycle, and each character that fits the chain launches a wavefront
// that moves one cell per cycle down the chain, so second-string characters
// stream back to back. After the request that ends the second string, the
// block waits for the last wavefront to leave the chain before the result
// is registered, and longer if an earlier response is still waiting to be
// taken; no request is taken during that drain. A string longer than MAX_LEN
// gives a response with overflow set and distance zero. Requests whose cmd
// does not match the current string are accepted and ignored.
module delete_only_edit_distance #(
   parameter int MAX_LEN = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dode_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dode_pkg::rsp_type rsp_data
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int VAL_W = $clog2(2 * MAX_LEN + 1);

   dode_pkg::state_type state_ff, state_in;
   logic [LEN_W-1:0]    flen_ff, flen_in;
   logic [LEN_W-1:0]    slen_ff, slen_in;
   logic [LEN_W-1:0]    cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic [VAL_W-1:0]    row0_ff, row0_in;
   logic [VAL_W-1:0]    diag0_ff, diag0_in;
   dode_pkg::link_type  head_ff, head_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dode_pkg::rsp_type   rsp_data_ff;

   logic                accept, a_item, b_item, b_push, capture;
   dode_pkg::cell_cmd_type cell_cmd;

   dode_pkg::link_type  link_w [0:MAX_LEN];
   logic [VAL_W-1:0]    diag_w [0:MAX_LEN];
   logic [VAL_W-1:0]    val_w  [0:MAX_LEN];

   assign accept = req_valid && req_ready;
   assign a_item = accept && (state_ff == dode_pkg::ST_LOAD)
                   && (req_data.cmd == dode_pkg::CMD_FIRST);
   assign b_item = accept && (state_ff == dode_pkg::ST_STREAM)
                   && (req_data.cmd == dode_pkg::CMD_SECOND);
   assign b_push = b_item && !req_data.no_char && (slen_ff != LEN_W'(MAX_LEN));

   // Controller outputs.
   always_comb begin
      req_ready = 1'b0;
      capture   = 1'b0;
      case (state_ff)
         dode_pkg::ST_LOAD:   req_ready = 1'b1;
         dode_pkg::ST_STREAM: req_ready = 1'b1;
         dode_pkg::ST_DRAIN:  capture = (cnt_ff == '0) && (!rsp_valid_ff || rsp_ready);
         default: begin
            req_ready = 1'b0;
            capture   = 1'b0;
         end
      endcase
   end

   // Controller next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dode_pkg::ST_LOAD: begin
            if (a_item && req_data.last) begin
               state_in = dode_pkg::ST_STREAM;
            end
         end
         dode_pkg::ST_STREAM: begin
            if (b_item && req_data.last) begin
               state_in = dode_pkg::ST_DRAIN;
            end
         end
         dode_pkg::ST_DRAIN: begin
            if (capture) begin
               state_in = dode_pkg::ST_LOAD;
            end
         end
         default: state_in = dode_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      flen_in        = flen_ff;
      slen_in        = slen_ff;
      ovf_in         = ovf_ff;
      row0_in        = row0_ff;
      diag0_in       = diag0_ff;
      cnt_in         = cnt_ff;
      head_in.valid  = 1'b0;
      head_in.ch     = req_data.char_value;
      cell_cmd.load  = 1'b0;
      cell_cmd.init  = 1'b0;
      cell_cmd.clear = capture;

      if (a_item && !req_data.no_char) begin
         if (flen_ff != LEN_W'(MAX_LEN)) begin
            cell_cmd.load = 1'b1;
            flen_in       = flen_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
      if (a_item && req_data.last) begin
         cell_cmd.init = 1'b1;
         row0_in       = '0;
         slen_in       = '0;
      end

      if (b_item && !req_data.no_char && !b_push) begin
         ovf_in = 1'b1;
      end
      if (b_push) begin
         slen_in       = slen_ff + LEN_W'(1);
         row0_in       = VAL_W'(slen_ff) + VAL_W'(1);
         diag0_in      = row0_ff;
         head_in.valid = 1'b1;
      end
      if (b_item && req_data.last) begin
         cnt_in = LEN_W'(MAX_LEN);
      end else if (state_ff == dode_pkg::ST_DRAIN && cnt_ff != '0) begin
         cnt_in = cnt_ff - LEN_W'(1);
      end

      if (capture) begin
         flen_in = '0;
         slen_in = '0;
         ovf_in  = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dode_pkg::ST_LOAD;
         flen_ff      <= '0;
         slen_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         flen_ff      <= flen_in;
         slen_ff      <= slen_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row0_ff  <= row0_in;
      diag0_ff <= diag0_in;
      if (capture) begin
         rsp_data_ff.overflow <= ovf_ff;
         rsp_data_ff.distance <= ovf_ff ? '0 : dode_pkg::DIST_W'(val_w[MAX_LEN]);
      end
   end

   assign link_w[0] = head_ff;
   assign diag_w[0] = diag0_ff;
   assign val_w[0]  = row0_ff;

   for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
      dode_cell #(
         .MAX_LEN(MAX_LEN),
         .IDX    (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cell_cmd),
         .load_ch (req_data.char_value),
         .load_idx(flen_ff),
         .init_len(flen_in),
         .link_in (link_w[k-1]),
         .left_val(val_w[k-1]),
         .diag_in (diag_w[k-1]),
         .link_out(link_w[k]),
         .diag_out(diag_w[k]),
         .val_out (val_w[k])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An overflowed response never carries a distance.
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.overflow || rsp_data.distance == '0))
      else $error("overflow response with nonzero distance");

   // A wavefront only enters the chain from a second-string request.
   a_wave_src: assert property (@(posedge clock) disable iff (reset)
      head_ff.valid |-> $past(state_ff == dode_pkg::ST_STREAM))
      else $error("wavefront launched outside streaming");

   // Capturing a result returns the lengths and overflow flag to zero.
   a_capture_clear: assert property (@(posedge clock) disable iff (reset)
      capture |=> (flen_ff == '0 && slen_ff == '0 && !ovf_ff
                   && state_ff == dode_pkg::ST_LOAD && rsp_valid_ff))
      else $error("capture did not clear controller state");

   // Lengths saturate at the chain length.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (flen_ff <= LEN_W'(MAX_LEN)) && (slen_ff <= LEN_W'(MAX_LEN)))
      else $error("string length beyond chain length");

endmodule

// File: hdl/dode_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delete-only edit distance cell
// Holds one character of the first string and one column of the distance
// row, and updates that column as each second-string character passes by.
// ---------------------------------------------------------------------------
module dode_cell #(
   parameter int MAX_LEN = 512,
   parameter int IDX     = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dode_pkg::cell_cmd_type              cmd,
   input  logic [dode_pkg::CHAR_W-1:0]         load_ch,
   input  logic [$clog2(MAX_LEN+1)-1:0]        load_idx,
   input  logic [$clog2(MAX_LEN+1)-1:0]        init_len,
   input  dode_pkg::link_type                  link_in,
   input  logic [$clog2(2*MAX_LEN+1)-1:0]      left_val,
   input  logic [$clog2(2*MAX_LEN+1)-1:0]      diag_in,
   output dode_pkg::link_type                  link_out,
   output logic [$clog2(2*MAX_LEN+1)-1:0]      diag_out,
   output logic [$clog2(2*MAX_LEN+1)-1:0]      val_out
);

   localparam int LEN_W = $clog2(MAX_LEN + 1);
   localparam int VAL_W = $clog2(2 * MAX_LEN + 1);

   logic                        active_ff, active_in;
   logic [dode_pkg::CHAR_W-1:0] ch_ff;
   logic [VAL_W-1:0]            val_ff, val_in;
   logic [VAL_W-1:0]            diag_ff, diag_in_next;
   dode_pkg::link_type          link_ff, link_in_next;
   logic                        load_here;
   logic [VAL_W-1:0]            min_val;

   assign load_here = cmd.load && (load_idx == LEN_W'(IDX - 1));

   always_comb begin
      if (cmd.clear) begin
         active_in = 1'b0;
      end else if (load_here) begin
         active_in = 1'b1;
      end else begin
         active_in = active_ff;
      end
   end

   assign min_val = (val_ff < left_val) ? val_ff : left_val;

   always_comb begin
      val_in       = val_ff;
      diag_in_next = diag_ff;
      link_in_next = link_in;
      if (cmd.init) begin
         // Columns past the end of the first string mirror its last column.
         val_in = active_in ? VAL_W'(IDX) : VAL_W'(init_len);
      end else if (link_in.valid) begin
         diag_in_next = val_ff;
         if (!active_ff) begin
            val_in = left_val;
         end else if (ch_ff == link_in.ch) begin
            val_in = diag_in;
         end else begin
            val_in = min_val + VAL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         link_ff   <= '0;
      end else begin
         active_ff <= active_in;
         link_ff   <= link_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (load_here) begin
         ch_ff <= load_ch;
      end
      val_ff  <= val_in;
      diag_ff <= diag_in_next;
   end

   assign link_out = link_ff;
   assign diag_out = diag_ff;
   assign val_out  = val_ff;

endmodule
